// ===== hdl/ppm_frame_generator_top_macros.svh =====
// ---------------------------------------------------------------------------
// ppm frame generator assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef PPM_FRAME_GENERATOR_TOP_MACROS_SVH
`define PPM_FRAME_GENERATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define PFG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PFG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PFG_ASSERT_IMP(label, ante, cons, msg)

`define PFG_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ===== hdl/ppmfg_pkg.sv =====
// ---------------------------------------------------------------------------
// ppmfg_pkg
// widths, limits, register codes and reset values of the ppm frame generator
// ---------------------------------------------------------------------------
`default_nettype none

package ppmfg_pkg;

    localparam int MAX_CHANNELS_DEFAULT = 8;

    // field widths
    localparam int CNT_W     = 4;
    localparam int PW_W      = 10;
    localparam int FL_W      = 16;
    localparam int IDX_IN_W  = 3;
    localparam int VAL_IN_W  = 12;
    localparam int STORE_W   = 11;
    localparam int SLOT_W    = 4;
    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // channel limits and sync floor
    localparam logic [STORE_W-1:0] CHAN_MIN    = STORE_W'(1000);
    localparam logic [STORE_W-1:0] CHAN_MAX    = STORE_W'(2000);
    localparam logic [STORE_W-1:0] CHAN_RESET  = STORE_W'(1500);
    localparam logic [STORE_W-1:0] STORE_SAT   = '1;
    localparam logic [TICK_W-1:0]  SYNC_LOW_MIN = TICK_W'(3000);

    // register reset values
    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(8);
    localparam logic [PW_W-1:0]  PULSE_RESET = PW_W'(300);
    localparam logic [FL_W-1:0]  FRAME_RESET = FL_W'(22500);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT = 2'd0,
        CFG_PULSE_WIDTH   = 2'd1,
        CFG_FRAME_LENGTH  = 2'd2
    } cfg_index_t;

    typedef enum logic {
        ACT_TICK  = 1'b0,
        ACT_WRITE = 1'b1
    } action_t;

    function automatic logic [STORE_W-1:0] clamp_chan(input logic [STORE_W-1:0] v);
        logic [STORE_W-1:0] r;
        r = v;
        if (v < CHAN_MIN) r = CHAN_MIN;
        if (v > CHAN_MAX) r = CHAN_MAX;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ppm_frame_generator_top.sv =====
// ---------------------------------------------------------------------------
// ppm_frame_generator_top
// rc ppm pin waveform generator, one microsecond tick or channel write per item
// ---------------------------------------------------------------------------
// Input items carry either a tick (action 0) or a channel write (action 1,
// channel_index and channel_value). Each accepted item gives exactly one
// result item: pin_level, frame_start and slot_number after that item.
// The result is registered and valid the cycle after acceptance, and one
// item is accepted every cycle while the result side keeps up. The state
// registers double as the result register, so in_stall rises only while a
// result is held and out_stall is high; a stalled result stays unchanged.
// Configuration writes (cfg_write, cfg_index, cfg_data) are registered and
// are meant for idle periods; pulse width, frame length and count are used
// when the next phase or slot is loaded.
// After reset the pin idles low, every channel holds 1500, the count is 8,
// the pulse 300 and the frame 22500 ticks; frames start on a tick with
// run_enable high. The sync gap costs one small multiply and two subtracts
// in the slot load path.
// ---------------------------------------------------------------------------
`default_nettype none

`include "ppm_frame_generator_top_macros.svh"

module ppm_frame_generator_top
    import ppmfg_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 action,
    input  wire logic [IDX_IN_W-1:0]  channel_index,
    input  wire logic [VAL_IN_W-1:0]  channel_value,
    input  wire logic                 run_enable,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      pin_level,
    output logic                      frame_start,
    output logic [SLOT_W-1:0]         slot_number
);

    localparam int ADDR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int USED_W = $clog2(MAX_CHANNELS * 2000 + 1);
    localparam int CMP_W  = 6;
    localparam int PROD_W = 15;
    localparam int GAP_W  = 18;

    // configuration registers
    logic [CNT_W-1:0] count_reg;
    logic [PW_W-1:0]  pulse_reg;
    logic [FL_W-1:0]  frame_reg;

    // channel store
    logic [STORE_W-1:0] store_reg [MAX_CHANNELS];

    // frame state, also the result register
    logic              active_reg,  active_next;
    logic [SLOT_W-1:0] slot_reg,    slot_next;
    logic              high_reg,    high_next;
    logic [TICK_W-1:0] rem_reg,     rem_next;
    logic [TICK_W-1:0] low_reg,     low_next;
    logic [USED_W-1:0] used_reg,    used_next;
    logic              pin_reg,     pin_next;
    logic              fs_reg,      fs_next;
    logic              ovalid_reg;

    logic               accept;
    logic               tick;
    logic               wr_hit;
    logic [ADDR_W-1:0]  wr_addr;
    logic [STORE_W-1:0] wr_val;

    logic [SLOT_W-1:0]  eff_n;
    logic               frame_go;
    logic               slot_go;
    logic [SLOT_W-1:0]  slot_tgt;
    logic [USED_W-1:0]  used_base;
    logic               tgt_is_chan;
    logic [STORE_W-1:0] chan_v;
    logic [STORE_W-1:0] chan_low;
    logic [PROD_W-1:0]  pulse_prod;
    logic signed [GAP_W-1:0] gap;
    logic [TICK_W-1:0]  low_tgt;
    logic [USED_W-1:0]  used_tgt;

    assign in_stall = ovalid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign tick     = accept && (action == ACT_TICK);

    // channel write path
    assign wr_hit  = CMP_W'(channel_index) < CMP_W'(MAX_CHANNELS);
    assign wr_addr = ADDR_W'(channel_index);
    assign wr_val  = channel_value[VAL_IN_W-1] ? STORE_SAT : channel_value[STORE_W-1:0];

    // count above the store depth acts as the full store
    assign eff_n = (CMP_W'(count_reg) > CMP_W'(MAX_CHANNELS)) ?
                   SLOT_W'(MAX_CHANNELS) : count_reg;

    assign frame_go = !active_reg ? run_enable :
                      (rem_reg == '0) && !high_reg && !(slot_reg < eff_n) && run_enable;
    assign slot_go  = active_reg && (rem_reg == '0) && !high_reg && (slot_reg < eff_n);

    // next slot load
    assign slot_tgt    = frame_go ? '0 : slot_reg + SLOT_W'(1);
    assign used_base   = frame_go ? '0 : used_reg;
    assign tgt_is_chan = slot_tgt < eff_n;
    assign chan_v      = clamp_chan(store_reg[ADDR_W'(slot_tgt)]);
    assign chan_low    = (chan_v > STORE_W'(pulse_reg)) ? chan_v - STORE_W'(pulse_reg) : '0;

    // sync gap: frame - used - (n + 1) * pulse, floored
    assign pulse_prod = PROD_W'(CMP_W'(eff_n) + CMP_W'(1)) * PROD_W'(pulse_reg);
    assign gap        = $signed(GAP_W'(frame_reg)) - $signed(GAP_W'(used_base))
                        - $signed(GAP_W'(pulse_prod));

    assign low_tgt  = tgt_is_chan ? TICK_W'(chan_low) :
                      (gap < $signed(GAP_W'(SYNC_LOW_MIN))) ? SYNC_LOW_MIN : gap[TICK_W-1:0];
    assign used_tgt = tgt_is_chan ? used_base + USED_W'(chan_v) : used_base;

    always_comb
    begin
        active_next = active_reg;
        slot_next   = slot_reg;
        high_next   = high_reg;
        rem_next    = rem_reg;
        low_next    = low_reg;
        used_next   = used_reg;
        pin_next    = pin_reg;
        fs_next     = fs_reg;
        if (accept)
        begin
            fs_next = 1'b0;
        end
        if (tick)
        begin
            if (frame_go || slot_go)
            begin
                active_next = 1'b1;
                slot_next   = slot_tgt;
                high_next   = 1'b1;
                pin_next    = 1'b1;
                rem_next    = TICK_W'(pulse_reg);
                low_next    = low_tgt;
                used_next   = used_tgt;
                fs_next     = frame_go;
            end
            else if (active_reg && (rem_reg == '0))
            begin
                if (high_reg)
                begin
                    high_next = 1'b0;
                    pin_next  = 1'b0;
                    rem_next  = low_reg;
                end
                else
                begin
                    // frame over and run cleared
                    active_next = 1'b0;
                    slot_next   = '0;
                    high_next   = 1'b0;
                    rem_next    = '0;
                    pin_next    = 1'b0;
                end
            end
            // the tick that starts a phase counts as its first
            if (active_next && (rem_next != '0))
            begin
                rem_next = rem_next - TICK_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= COUNT_RESET;
            pulse_reg  <= PULSE_RESET;
            frame_reg  <= FRAME_RESET;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                store_reg[i] <= CHAN_RESET;
            end
            active_reg <= 1'b0;
            slot_reg   <= '0;
            high_reg   <= 1'b0;
            rem_reg    <= '0;
            low_reg    <= '0;
            used_reg   <= '0;
            pin_reg    <= 1'b0;
            fs_reg     <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_CHANNEL_COUNT: count_reg <= cfg_data[CNT_W-1:0];
                    CFG_PULSE_WIDTH:   pulse_reg <= cfg_data[PW_W-1:0];
                    CFG_FRAME_LENGTH:  frame_reg <= cfg_data[FL_W-1:0];
                    default:           ;
                endcase
            end
            if (accept && (action == ACT_WRITE) && wr_hit)
            begin
                store_reg[wr_addr] <= wr_val;
            end
            active_reg <= active_next;
            slot_reg   <= slot_next;
            high_reg   <= high_next;
            rem_reg    <= rem_next;
            low_reg    <= low_next;
            used_reg   <= used_next;
            pin_reg    <= pin_next;
            fs_reg     <= fs_next;
            if (accept)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = ovalid_reg;
    assign pin_level   = pin_reg;
    assign frame_start = fs_reg;
    assign slot_number = slot_reg;

    `PFG_ASSERT_IMP(a_idle_low, !active_reg, !pin_reg && (slot_reg == '0), "idle pin not low")
    `PFG_ASSERT_IMP(a_pin_phase, active_reg, pin_reg == high_reg, "pin disagrees with phase")
    `PFG_ASSERT_IMP(a_frame_slot0, ovalid_reg && fs_reg, pin_reg && (slot_reg == '0), "bad frame start")
    `PFG_ASSERT_NXT(a_write_hold, accept && (action == ACT_WRITE), $stable(pin_reg) && $stable(slot_reg) && !fs_reg, "write item moved the waveform")

endmodule

`default_nettype wire
